[hw/rtl/icpt_pkg.sv]
// Package for the ICMP probe tracker: beat payload types, table entry type,
// parser result type and register and result codes. No dependencies.
package icpt_pkg;

	localparam logic [7:0] REG_IPV6_MODE = 8'd0;
	localparam logic [7:0] REG_OWN_ID    = 8'd1;
	localparam logic [7:0] REG_KEY_LOW   = 8'd2;
	localparam logic [7:0] REG_KEY_HIGH  = 8'd3;

	localparam logic KIND_PROBE = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	localparam logic [1:0] RK_ACCEPT   = 2'd0;
	localparam logic [1:0] RK_DROP     = 2'd1;
	localparam logic [1:0] RK_REPLY    = 2'd2;
	localparam logic [1:0] RK_EXCEEDED = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  hop_limit;
		logic [15:0] sequence_req;
		logic [63:0] tag;
		logic [7:0]  packet_byte;
		logic        packet_end;
		logic [63:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  out_hop_limit;
		logic [15:0] out_sequence;
		logic [15:0] echo_checksum;
		logic [63:0] round_trip_us;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] seq;
		logic [7:0]  hop;
		logic [63:0] send_time;
	} entry_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [15:0] id;
		logic [15:0] seq;
	} parse_res_t;

endpackage

[hw/rtl/icmp_probe_tracker_unit.sv]
// ICMP probe tracker top level: probe table in RAM, SipHash check, parser.
// Depends on icpt_pkg, icpt_ram, icpt_siphash and icpt_parser.
//
// One input channel (in_valid, in_stall, in_data) carries either a probe
// intent or one received packet byte. One output channel (out_valid,
// out_stall, out_data) carries results. Configuration is written through
// cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready is always high.
// Non-final packet bytes stream one per cycle while the block is idle.
// A probe intent goes through the SipHash unit, which does one half round
// per cycle; then the table is written if the tag matches, and the result
// is handed off. A final packet byte goes through parser result, index
// reduction with the registered RAM read, compare and clear, and hand-off.
// After reset the block first clears the probe table, one entry per cycle,
// all TABLE_DEPTH entries (1024 by default), with in_stall high.
// The result sits in an output register; while out_stall is high it holds,
// and the block keeps taking packet bytes, waiting only when a new result
// must be handed off.
module icmp_probe_tracker_unit import icpt_pkg::*; #(
	parameter int TABLE_DEPTH      = 1024,
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / TABLE_DEPTH);
	localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PKT   = 3'd3;
	localparam logic [2:0] ST_MOD   = 3'd4;
	localparam logic [2:0] ST_CMP   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]       state_q;
	logic             ipv6_q;
	logic [15:0]      own_id_q;
	logic [63:0]      key_low_q, key_high_q;
	logic [IDX_W-1:0] clr_q, idx_q, idx_c;
	logic [48:0]      prod_q;
	logic [33:0]      qd_c;
	logic [16:0]      rem_c;
	logic [7:0]       hop_q;
	logic [15:0]      seq_q;
	logic [63:0]      tag_q, time_q;
	logic [1:0]       kind_q;
	out_item_t        res_q, out_q;
	logic             out_valid_q;
	logic             accept, sip_done;
	logic [63:0]      sip_hash;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	logic             pres_valid;
	parse_res_t       pres;
	logic [17:0]      sum0;
	logic [16:0]      sum1, sum2;
	logic [15:0]      csum;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;

	always_comb begin
		qd_c  = 34'(prod_q[48:32]) * 34'(DEPTH_V);
		rem_c = 17'(34'(seq_q) - qd_c);
		if (rem_c >= DEPTH_V) rem_c = rem_c - DEPTH_V;
		idx_c = rem_c[IDX_W-1:0];
		sum0  = 18'h0800 + 18'(own_id_q) + 18'(seq_q);
		sum1  = 17'(sum0[15:0]) + 17'(sum0[17:16]);
		sum2  = 17'(sum1[15:0]) + 17'(sum1[16]);
		csum  = ~sum2[15:0];
	end

	icpt_siphash u_sip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && in_data.kind == KIND_PROBE),
		.m      ({40'd0, in_data.hop_limit, in_data.sequence_req}),
		.k0     (key_low_q),
		.k1     (key_high_q),
		.done   (sip_done),
		.hash   (sip_hash)
	);

	icpt_parser #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (accept && in_data.kind == KIND_BYTE),
		.data      (in_data.packet_byte),
		.last      (in_data.packet_end),
		.ipv6_mode (ipv6_q),
		.res_valid (pres_valid),
		.res       (pres)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_c;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_HASH: begin
				if (sip_done && sip_hash == tag_q) begin
					ram_we    = 1'b1;
					ram_wdata = '{valid: 1'b1, seq: seq_q, hop: hop_q, send_time: time_q};
				end
			end
			ST_CMP: begin
				if (ram_rdata.valid && ram_rdata.seq == seq_q) ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	icpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			ipv6_q      <= 1'b0;
			own_id_q    <= '0;
			key_low_q   <= '0;
			key_high_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IPV6_MODE: ipv6_q     <= cfg_data[0];
					REG_OWN_ID:    own_id_q   <= cfg_data[15:0];
					REG_KEY_LOW:   key_low_q  <= cfg_data;
					REG_KEY_HIGH:  key_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(TABLE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && in_data.kind == KIND_PROBE) state_q <= ST_HASH;
					else if (accept && in_data.packet_end) state_q <= ST_PKT;
				end
				ST_HASH: begin
					if (sip_done) state_q <= ST_EMIT;
				end
				ST_PKT: begin
					if (pres_valid && pres.hit && pres.id == own_id_q) state_q <= ST_MOD;
					else state_q <= ST_IDLE;
				end
				ST_MOD: state_q <= ST_CMP;
				ST_CMP: begin
					if (ram_rdata.valid && ram_rdata.seq == seq_q) state_q <= ST_EMIT;
					else state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_data.kind == KIND_PROBE) begin
			hop_q  <= in_data.hop_limit;
			seq_q  <= in_data.sequence_req;
			tag_q  <= in_data.tag;
			prod_q <= 49'(in_data.sequence_req) * 49'(RECIP);
		end
		if (state_q == ST_IDLE && accept) time_q <= in_data.time_us;
		if (state_q == ST_HASH || state_q == ST_MOD) idx_q <= idx_c;
		if (state_q == ST_PKT) begin
			seq_q  <= pres.seq;
			kind_q <= pres.kind;
			prod_q <= 49'(pres.seq) * 49'(RECIP);
		end
		if (state_q == ST_HASH && sip_done) begin
			res_q.out_hop_limit <= hop_q;
			res_q.out_sequence  <= seq_q;
			res_q.round_trip_us <= '0;
			if (sip_hash == tag_q) begin
				res_q.result_kind   <= RK_ACCEPT;
				res_q.echo_checksum <= ipv6_q ? 16'd0 : csum;
			end else begin
				res_q.result_kind   <= RK_DROP;
				res_q.echo_checksum <= '0;
			end
		end
		if (state_q == ST_CMP) begin
			res_q.result_kind   <= kind_q;
			res_q.out_hop_limit <= ram_rdata.hop;
			res_q.out_sequence  <= seq_q;
			res_q.echo_checksum <= '0;
			res_q.round_trip_us <= time_q - ram_rdata.send_time;
		end
		if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

[hw/rtl/icpt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module icpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/icpt_siphash.sv]
// Iterative SipHash-2-4 of one 64-bit word, one half round per cycle.
// No dependencies.
module icpt_siphash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] m,
	input  logic [63:0] k0,
	input  logic [63:0] k1,
	output logic        done,
	output logic [63:0] hash
);
	logic [63:0] v0_q, v1_q, v2_q, v3_q, m_q;
	logic [63:0] a0, a1, a2, a3;
	logic [3:0]  step_q;
	logic        busy_q, done_q;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

	always_comb begin
		a0 = v0_q;
		a1 = v1_q;
		a2 = v2_q;
		a3 = v3_q;
		if (!step_q[0]) begin
			a0 = v0_q + v1_q;
			a1 = rotl(v1_q, 13) ^ a0;
			a0 = rotl(a0, 32);
			a2 = v2_q + v3_q;
			a3 = rotl(v3_q, 16) ^ a2;
		end else begin
			a0 = v0_q + v3_q;
			a3 = rotl(v3_q, 21) ^ a0;
			a2 = v2_q + v1_q;
			a1 = rotl(v1_q, 17) ^ a2;
			a2 = rotl(a2, 32);
		end
		if (step_q == 4'd3) begin
			a0 = a0 ^ m_q;
			a3 = a3 ^ (64'd8 << 56);
		end
		if (step_q == 4'd7) begin
			a0 = a0 ^ (64'd8 << 56);
			a2 = a2 ^ 64'hff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v0_q <= k0 ^ 64'h736f6d6570736575;
			v1_q <= k1 ^ 64'h646f72616e646f6d;
			v2_q <= k0 ^ 64'h6c7967656e657261;
			v3_q <= k1 ^ 64'h7465646279746573 ^ m;
			m_q  <= m;
		end else if (busy_q) begin
			v0_q <= a0;
			v1_q <= a1;
			v2_q <= a2;
			v3_q <= a3;
		end
	end

	assign done = done_q;
	assign hash = v0_q ^ v1_q ^ v2_q ^ v3_q;
endmodule

[hw/rtl/icpt_parser.sv]
// Streaming ICMP parser: picks type, identifier and sequence out of the
// packet bytes as they pass. Depends on icpt_pkg.
module icpt_parser import icpt_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat,
	input  logic [7:0] data,
	input  logic       last,
	input  logic       ipv6_mode,
	output logic       res_valid,
	output parse_res_t res
);
	localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

	logic [PW-1:0] pos_q;
	logic [7:0]    h_q, idpos_q;
	logic [1:0]    kind_q, kind_c;
	logic          idok_q, idok_c, got_q, got_c;
	logic [15:0]   id_q, id_c, seq_q, seq_c;
	logic [7:0]    h_c, idpos_c;
	logic [16:0]   p;
	logic          store;
	logic          res_valid_q;
	parse_res_t    res_q;

	always_comb begin
		p       = 17'(pos_q);
		store   = pos_q < PW'(MAX_PACKET_BYTES);
		h_c     = (pos_q == '0) ? {2'b00, data[3:0], 2'b00} : h_q;
		kind_c  = kind_q;
		idok_c  = idok_q;
		idpos_c = idpos_q;
		got_c   = got_q;
		id_c    = id_q;
		seq_c   = seq_q;
		if (store) begin
			if (ipv6_mode) begin
				if (pos_q == '0) begin
					if (data == 8'd129) begin
						kind_c = RK_REPLY; idok_c = 1'b1; idpos_c = 8'd4;
					end else if (data == 8'd3) begin
						kind_c = RK_EXCEEDED; idok_c = 1'b1; idpos_c = 8'd52;
					end
				end
			end else begin
				if (p == 17'(h_c)) begin
					if (data == 8'd0) begin
						kind_c = RK_REPLY; idok_c = 1'b1; idpos_c = h_c + 8'd4;
					end else if (data == 8'd11) begin
						kind_c = RK_EXCEEDED;
					end
				end
				if (kind_q == RK_EXCEEDED && !idok_q && p == 17'(h_q) + 17'd8) begin
					idok_c  = 1'b1;
					idpos_c = h_q + 8'd12 + {2'b00, data[3:0], 2'b00};
				end
			end
			if (idok_q) begin
				if (p == 17'(idpos_q)) id_c[15:8] = data;
				if (p == 17'(idpos_q) + 17'd1) id_c[7:0] = data;
				if (p == 17'(idpos_q) + 17'd2) seq_c[15:8] = data;
				if (p == 17'(idpos_q) + 17'd3) begin
					seq_c[7:0] = data;
					got_c = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			h_q         <= '0;
			kind_q      <= '0;
			idok_q      <= 1'b0;
			idpos_q     <= '0;
			got_q       <= 1'b0;
			id_q        <= '0;
			seq_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= beat && last;
			if (beat) begin
				if (last) begin
					pos_q  <= '0;
					h_q    <= '0;
					kind_q <= '0;
					idok_q <= 1'b0;
					got_q  <= 1'b0;
				end else begin
					if (store) pos_q <= pos_q + PW'(1);
					h_q     <= h_c;
					kind_q  <= kind_c;
					idok_q  <= idok_c;
					idpos_q <= idpos_c;
					got_q   <= got_c;
					id_q    <= id_c;
					seq_q   <= seq_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat && last) begin
			res_q.hit  <= got_c;
			res_q.kind <= kind_c;
			res_q.id   <= id_c;
			res_q.seq  <= seq_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

[hw/rtl/icpt_checker.sv]
// Port-level checker for the ICMP probe tracker, bound to the top level.
// Depends on icpt_pkg and icmp_probe_tracker_unit.
module icpt_checker import icpt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result beat changed");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == RK_DROP |->
		out_data.echo_checksum == 16'd0 && out_data.round_trip_us == 64'd0)
		else $error("dropped probe carries checksum or time");

	a_accept_rtt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == RK_ACCEPT |-> out_data.round_trip_us == 64'd0)
		else $error("accepted probe carries a round-trip time");

	a_probe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.kind == KIND_PROBE |=> in_stall)
		else $error("probe beat not followed by hash interval");
endmodule

bind icmp_probe_tracker_unit icpt_checker u_icpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[bench/icmp_probe_tracker_unit_tb.sv]
// Testbench for icmp_probe_tracker_unit: probe intents, reply and time-exceeded
// packets, register settings and backpressure, checked against an in-bench predictor.
// Depends on icpt_pkg and the icmp_probe_tracker_unit RTL.
module icmp_probe_tracker_unit_tb;
	import icpt_pkg::*;

	typedef logic [7:0] pkt_bytes_t[$];

	localparam int          DEPTH     = 1024;
	localparam int          MAX_BYTES = 2048;
	localparam int          IN_W      = $bits(in_item_t);
	localparam logic [7:0]  REG_SPARE = 8'd9;
	localparam logic [7:0]  ICMP4_REPLY    = 8'd0;
	localparam logic [7:0]  ICMP4_EXCEEDED = 8'd11;
	localparam logic [7:0]  ICMP6_REPLY    = 8'd129;
	localparam logic [7:0]  ICMP6_EXCEEDED = 8'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;

	icmp_probe_tracker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the registers and the probe table.
	logic        mdl_ipv6;
	logic [15:0] mdl_own_id;
	logic [63:0] mdl_k0, mdl_k1;
	logic        tbl_valid[DEPTH];
	logic [15:0] tbl_seq[DEPTH];
	logic [7:0]  tbl_hop[DEPTH];
	logic [63:0] tbl_sent[DEPTH];
	logic [7:0]  rx_mem[MAX_BYTES];
	int          rx_len;

	out_item_t   pending_results[$];
	logic [15:0] live_seqs[$];
	logic [63:0] now_us;
	int          errors;
	int          items_sent;
	int          results_seen;
	int          hold_req;
	int          stall_left;
	bit          quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [63:0] rotl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [255:0] sip_round(logic [255:0] s);
		logic [63:0] a, b, c, d;
		{a, b, c, d} = s;
		a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
		c = c + d; d = rotl(d, 16); d = d ^ c;
		a = a + d; d = rotl(d, 21); d = d ^ a;
		c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
		return {a, b, c, d};
	endfunction

	function automatic logic [63:0] probe_tag(logic [7:0] hop, logic [15:0] seq);
		logic [63:0] m, fin, a, b, c, d;
		m = {40'd0, hop, seq};
		fin = 64'd8 << 56;
		a = mdl_k0 ^ 64'h736f6d6570736575;
		b = mdl_k1 ^ 64'h646f72616e646f6d;
		c = mdl_k0 ^ 64'h6c7967656e657261;
		d = mdl_k1 ^ 64'h7465646279746573 ^ m;
		{a, b, c, d} = sip_round(sip_round({a, b, c, d}));
		a = a ^ m;
		d = d ^ fin;
		{a, b, c, d} = sip_round(sip_round({a, b, c, d}));
		a = a ^ fin;
		c = c ^ 64'hff;
		for (int i = 0; i < 4; i++)
			{a, b, c, d} = sip_round({a, b, c, d});
		return a ^ b ^ c ^ d;
	endfunction

	function automatic logic [15:0] rx_word(int pos);
		return {rx_mem[pos], rx_mem[pos + 1]};
	endfunction

	// Works out the result of one accepted beat and queues it when there is one.
	task automatic track_beat(in_item_t it);
		out_item_t   r;
		logic [17:0] sum;
		logic [1:0]  rk;
		logic [15:0] id, sq;
		int          h, idpos, len;
		bit          hit;
		r = '0;
		if (it.kind == KIND_PROBE) begin
			r.out_hop_limit = it.hop_limit;
			r.out_sequence = it.sequence_req;
			if (it.tag != probe_tag(it.hop_limit, it.sequence_req)) begin
				r.result_kind = RK_DROP;
			end else begin
				tbl_valid[it.sequence_req[9:0]] = 1'b1;
				tbl_seq[it.sequence_req[9:0]] = it.sequence_req;
				tbl_hop[it.sequence_req[9:0]] = it.hop_limit;
				tbl_sent[it.sequence_req[9:0]] = it.time_us;
				r.result_kind = RK_ACCEPT;
				if (!mdl_ipv6) begin
					sum = 18'h0800 + 18'(mdl_own_id) + 18'(it.sequence_req);
					sum = 18'(sum[15:0]) + 18'(sum[17:16]);
					sum = 18'(sum[15:0]) + 18'(sum[17:16]);
					r.echo_checksum = ~sum[15:0];
				end
			end
			pending_results.push_back(r);
			return;
		end
		if (rx_len < MAX_BYTES) begin
			rx_mem[rx_len] = it.packet_byte;
			rx_len++;
		end
		if (!it.packet_end)
			return;
		len = rx_len;
		rx_len = 0;
		hit = 1'b0;
		idpos = 0;
		if (mdl_ipv6) begin
			if (rx_mem[0] == ICMP6_REPLY) begin
				idpos = 4; rk = RK_REPLY; hit = 1'b1;
			end else if (rx_mem[0] == ICMP6_EXCEEDED) begin
				idpos = 52; rk = RK_EXCEEDED; hit = 1'b1;
			end
		end else begin
			h = 4 * rx_mem[0][3:0];
			if (h < len) begin
				if (rx_mem[h] == ICMP4_REPLY) begin
					idpos = h + 4; rk = RK_REPLY; hit = 1'b1;
				end else if (rx_mem[h] == ICMP4_EXCEEDED && h + 8 < len) begin
					idpos = h + 12 + 4 * rx_mem[h + 8][3:0];
					rk = RK_EXCEEDED; hit = 1'b1;
				end
			end
		end
		if (!hit || idpos + 4 > len)
			return;
		id = rx_word(idpos);
		sq = rx_word(idpos + 2);
		if (id != mdl_own_id || !tbl_valid[sq[9:0]] || tbl_seq[sq[9:0]] != sq)
			return;
		tbl_valid[sq[9:0]] = 1'b0;
		r.result_kind = rk;
		r.out_hop_limit = tbl_hop[sq[9:0]];
		r.out_sequence = sq;
		r.round_trip_us = it.time_us - tbl_sent[sq[9:0]];
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", out_data.round_trip_us, 64'd0);
			end else begin
				w = pending_results.pop_front();
				if (out_data.result_kind != w.result_kind)
					report_mismatch("result_kind", 64'(out_data.result_kind),
						64'(w.result_kind));
				if (out_data.out_hop_limit != w.out_hop_limit)
					report_mismatch("out_hop_limit", 64'(out_data.out_hop_limit),
						64'(w.out_hop_limit));
				if (out_data.out_sequence != w.out_sequence)
					report_mismatch("out_sequence", 64'(out_data.out_sequence),
						64'(w.out_sequence));
				if (out_data.echo_checksum != w.echo_checksum)
					report_mismatch("echo_checksum", 64'(out_data.echo_checksum),
						64'(w.echo_checksum));
				if (out_data.round_trip_us != w.round_trip_us)
					report_mismatch("round_trip_us", out_data.round_trip_us, w.round_trip_us);
			end
		end
	end

	// Receiver side: a requested hold-off first, otherwise random stalls unless quiet is set.
	always @(negedge clk) begin
		int r;
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req <= hold_req - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(in_item_t it);
		int gap;
		if ($urandom_range(0, 19) == 0)
			now_us = {$urandom, $urandom};
		else
			now_us = now_us + 64'($urandom_range(0, 500));
		it.time_us = now_us;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		track_beat(it);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_probe(logic [7:0] hop, logic [15:0] seq, bit good);
		in_item_t it;
		it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		it.kind = KIND_PROBE;
		it.hop_limit = hop;
		it.sequence_req = seq;
		it.tag = good ? probe_tag(hop, seq) : {$urandom, $urandom};
		if (!good && it.tag == probe_tag(hop, seq))
			it.tag = ~it.tag;
		send_beat(it);
		if (good) begin
			live_seqs.push_back(seq);
			if (live_seqs.size() > 48)
				void'(live_seqs.pop_front());
		end
	endtask

	task automatic send_bytes(pkt_bytes_t pkt, int from, int upto, bit ends);
		in_item_t it;
		for (int i = from; i < upto; i++) begin
			it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			it.kind = KIND_BYTE;
			it.packet_byte = pkt[i];
			it.packet_end = ends && (i == upto - 1);
			send_beat(it);
		end
	endtask

	function automatic pkt_bytes_t build_pkt(logic [1:0] rk, logic [15:0] id,
			logic [15:0] seq, bit v6);
		pkt_bytes_t p;
		int ihl, inner, idpos, len;
		ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : 5;
		inner = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : 5;
		if (v6)
			idpos = (rk == RK_REPLY) ? 4 : 52;
		else
			idpos = (rk == RK_REPLY) ? 4 * ihl + 4 : 4 * ihl + 12 + 4 * inner;
		len = idpos + 4 + $urandom_range(0, 6);
		for (int i = 0; i < len; i++)
			p.push_back(8'($urandom));
		if (v6) begin
			p[0] = (rk == RK_REPLY) ? ICMP6_REPLY : ICMP6_EXCEEDED;
		end else begin
			p[0] = {4'h4, ihl[3:0]};
			p[4 * ihl] = (rk == RK_REPLY) ? ICMP4_REPLY : ICMP4_EXCEEDED;
			if (rk == RK_EXCEEDED)
				p[4 * ihl + 8] = {4'h4, inner[3:0]};
		end
		{p[idpos], p[idpos + 1], p[idpos + 2], p[idpos + 3]} = {id, seq};
		return p;
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IPV6_MODE: mdl_ipv6 = val[0];
			REG_OWN_ID:    mdl_own_id = val[15:0];
			REG_KEY_LOW:   mdl_k0 = val;
			REG_KEY_HIGH:  mdl_k1 = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_reply(logic [15:0] seq, logic [1:0] rk, bit right_id);
		pkt_bytes_t p;
		p = build_pkt(rk, right_id ? mdl_own_id : mdl_own_id ^ 16'h0101, seq, mdl_ipv6);
		send_bytes(p, 0, p.size(), 1'b1);
	endtask

	task automatic test_probe_extremes();
		write_reg(REG_KEY_LOW, 64'h0706050403020100);
		write_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		write_reg(REG_OWN_ID, 64'hFFFF_0000_0000_F7FF);
		send_probe(8'd0, 16'd0, 1'b1);
		send_probe(8'd255, 16'hFFFF, 1'b1);
		send_probe(8'd64, 16'h1234, 1'b0);
		send_probe(8'd1, 16'h0400, 1'b1);
		send_reply(16'hFFFF, RK_REPLY, 1'b1);
		send_reply(16'h0000, RK_EXCEEDED, 1'b1);
	endtask

	task automatic test_packet_cases();
		pkt_bytes_t p;
		send_probe(8'd7, 16'h0077, 1'b1);
		send_reply(16'h0077, RK_REPLY, 1'b0);
		p = build_pkt(RK_REPLY, mdl_own_id, 16'h0077, 1'b0);
		send_bytes(p, 0, 5, 1'b0);
		send_probe(8'd9, 16'h0177, 1'b1);
		send_bytes(p, 5, p.size(), 1'b1);
		send_reply(16'h0077, RK_REPLY, 1'b1);
		send_reply(16'h0177, RK_EXCEEDED, 1'b1);
		send_probe(8'd3, 16'h0300, 1'b1);
		p = build_pkt(RK_REPLY, mdl_own_id, 16'h0300, 1'b0);
		send_bytes(p, 0, p.size() - 1, 1'b0);
		send_bytes(p, p.size() - 2, p.size() - 1, 1'b1);
		p = build_pkt(RK_REPLY, mdl_own_id, 16'h0300, 1'b0);
		p[20] = 8'd8;
		send_bytes(p, 0, p.size(), 1'b1);
		p = {8'h00, 8'h00, 8'h00, 8'h00, mdl_own_id[15:8], mdl_own_id[7:0], 8'h03, 8'h00};
		send_bytes(p, 0, p.size(), 1'b1);
		send_probe(8'd4, 16'h0700, 1'b1);
		send_probe(8'd5, 16'h0300, 1'b1);
		send_reply(16'h0700, RK_REPLY, 1'b1);
		wait_idle();
	endtask

	task automatic test_oversized_packet();
		pkt_bytes_t p;
		send_probe(8'd33, 16'h2222, 1'b1);
		p = build_pkt(RK_REPLY, mdl_own_id, 16'h2222, 1'b0);
		while (p.size() < MAX_BYTES + 40)
			p.push_back(8'($urandom));
		quiet = 1'b1;
		send_bytes(p, 0, p.size(), 1'b1);
		quiet = 1'b0;
		wait_idle();
	endtask

	task automatic test_register_settings();
		write_reg(REG_IPV6_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_OWN_ID, 64'd0);
		write_reg(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_KEY_HIGH, 64'd0);
		write_reg(REG_SPARE, 64'h1);
		write_reg(8'hFF, 64'h0);
		send_probe(8'd200, 16'hABCD, 1'b1);
		send_probe(8'd201, 16'h0102, 1'b1);
		send_reply(16'hABCD, RK_REPLY, 1'b1);
		send_reply(16'h0102, RK_EXCEEDED, 1'b1);
		wait_idle();
		write_reg(REG_IPV6_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		write_reg(REG_OWN_ID, 64'hABCD_0000_0000_FFFF);
		write_reg(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		send_probe(8'd17, 16'hF7FF, 1'b1);
		send_probe(8'd18, 16'h0800, 1'b1);
		send_reply(16'hF7FF, RK_EXCEEDED, 1'b1);
		wait_idle();
	endtask

	task automatic run_random_mix(int count);
		pkt_bytes_t p;
		int stop, r, n;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 40 || live_seqs.size() == 0) begin
				send_probe(8'($urandom), 16'($urandom), $urandom_range(0, 99) < 85);
			end else if (r < 88) begin
				p = build_pkt($urandom_range(0, 1) ? RK_REPLY : RK_EXCEEDED,
					($urandom_range(0, 9) == 0) ? 16'($urandom) : mdl_own_id,
					live_seqs[$urandom_range(0, live_seqs.size() - 1)], mdl_ipv6);
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, p.size() - 1);
					while (p.size() > n)
						void'(p.pop_back());
				end
				send_bytes(p, 0, p.size(), 1'b1);
			end else begin
				p = {};
				n = $urandom_range(1, 24);
				for (int i = 0; i < n; i++)
					p.push_back(8'($urandom));
				send_bytes(p, 0, n, 1'b1);
			end
		end
	endtask

	task automatic test_random_traffic();
		write_reg(REG_OWN_ID, {$urandom, $urandom});
		write_reg(REG_KEY_LOW, {$urandom, $urandom});
		write_reg(REG_KEY_HIGH, {$urandom, $urandom});
		live_seqs = {};
		run_random_mix(900);
		wait_idle();
		write_reg(REG_IPV6_MODE, 64'd1);
		live_seqs = {};
		run_random_mix(450);
		wait_idle();
		write_reg(REG_IPV6_MODE, 64'd0);
	endtask

	task automatic test_backpressure();
		quiet = 1'b1;
		hold_req = 300;
		for (int i = 0; i < 40; i++)
			send_probe(8'($urandom), 16'($urandom), i % 5 != 0);
		for (int i = 0; i < 10; i++)
			send_reply(live_seqs[live_seqs.size() - 1 - i], RK_REPLY, 1'b1);
		wait_idle();
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		hold_req = 0;
		stall_left = 0;
		quiet = 1'b0;
		now_us = 64'd1000;
		mdl_ipv6 = 1'b0;
		mdl_own_id = '0;
		mdl_k0 = '0;
		mdl_k1 = '0;
		rx_len = 0;
		for (int i = 0; i < DEPTH; i++)
			tbl_valid[i] = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_probe_extremes();
		test_packet_cases();
		test_oversized_packet();
		test_register_settings();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		$display("Sent %0d beats (probes, reply and time-exceeded packets, noise) in IPv4 and",
			items_sent);
		$display("IPv6 modes under random stalls; %0d result beats checked.", results_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
